>>> rtl/hamming_windowed_stft_macros.svh
// Assertion macros for the STFT RTL.
// No dependencies; pulled in by the top level with an include.
`ifndef HAMMING_WINDOWED_STFT_MACROS_SVH
`define HAMMING_WINDOWED_STFT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define HWS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define HWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hws_pkg.sv
// Package for the Hamming-windowed STFT: constants, types and the
// elaboration-time functions that build the window and twiddle tables.
package hws_pkg;

    localparam int FRAME_SIZE_DEF = 64;
    localparam int HOP_W          = 7;
    localparam int SAMPLE_W       = 16;
    localparam int BIN_W          = 6;
    localparam int OUT_W          = 22;
    localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_OUT
    } t_state;

    // Control handed from the sequencer to the MAC datapath.
    typedef struct packed {
        logic vld;   // a sample word with its indexes enters the datapath
        logic clr;   // clear the accumulators for a new bin
    } t_mac_ctl;

    // Status returned by the datapath.
    typedef struct packed {
        logic busy;  // products still in flight
    } t_mac_sts;

    // Fraction p/q of a turn as unsigned Q0.32, by long division.
    function automatic logic [31:0] hws_phase(input int unsigned p, input int unsigned q);
        logic [63:0] num;
        logic [63:0] quo;
        logic [64:0] rem;
        int unsigned pp;
        pp  = p;
        if (pp >= q) begin
            pp = pp - q;
        end
        num = {32'(pp), 32'd0};
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= 65'(q)) begin
                rem    = rem - 65'(q);
                quo[i] = 1'b1;
            end
        end
        return quo[31:0];
    endfunction

    // Integer cosine of a phase in Q0.32 turns, result in Q15.
    function automatic logic signed [15:0] hws_cosq(input logic [31:0] t);
        logic [31:0] u;
        logic        neg;
        logic [63:0] x, x2, a, prod, c, q;
        u   = t;
        neg = 1'b0;
        if (u >= 32'h8000_0000) begin
            u = 32'd0 - u;
        end
        if (u > 32'h4000_0000) begin
            neg = 1'b1;
            u   = 32'h8000_0000 - u;
        end
        x    = (64'(u) * 64'd6746518852) >> 32;
        x2   = (x * x) >> 30;
        a    = (64'd1 << 30) - x2 / 64'd90;
        a    = (64'd1 << 30) - ((x2 * a) >> 30) / 64'd56;
        a    = (64'd1 << 30) - ((x2 * a) >> 30) / 64'd30;
        a    = (64'd1 << 30) - ((x2 * a) >> 30) / 64'd12;
        prod = ((x2 * a) >> 30) / 64'd2;
        c    = (prod >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - prod;
        q    = (c + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return neg ? -$signed(16'(q)) : $signed(16'(q));
    endfunction

    // Hamming window tap n of an N-point frame, Q1.15.
    function automatic logic signed [15:0] hws_window(input int unsigned n, input int unsigned len);
        logic signed [63:0] c;
        logic signed [63:0] w;
        c = 64'(hws_cosq(hws_phase(n, len - 1)));
        w = (64'sd579820585 - 64'sd15073 * c + 64'sd16384) >>> 15;
        if (w > 64'sd32767) begin
            w = 64'sd32767;
        end
        return 16'(w);
    endfunction

    function automatic logic signed [15:0] hws_cos(input int unsigned m, input int unsigned len);
        return hws_cosq(hws_phase(m, len));
    endfunction

    function automatic logic signed [15:0] hws_sin(input int unsigned m, input int unsigned len);
        return hws_cosq(hws_phase(m, len) - 32'h4000_0000);
    endfunction

endpackage

>>> rtl/hamming_windowed_stft.sv
// Hamming-windowed short-time Fourier transform, top level.
// Depends on hws_pkg, hws_mac and hamming_windowed_stft_macros.svh.
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one word: a signed 16-bit
//   sample and a restart flag. Restart begins a new signal: the frame fill
//   and hop count clear before the sample is stored.
//   Once FRAME_SIZE samples of a signal are in, a frame is due, and then one
//   every hop-length samples (a hop of zero acts as one). A due frame, oldest
//   sample first, is windowed and transformed by a direct DFT with exact
//   accumulation; FRAME_SIZE bin words leave on the output channel
//   (o_out_valid / i_out_stall), bin 0 first, the last one flagged.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the hop length;
//   it is always ready and must only be used while the block is idle.
// Timing:
//   A sample that makes no frame causes no stall. For each bin of a frame,
//   FRAME_SIZE ring reads issue one per cycle, four pipeline stages drain,
//   and the output state follows. The input stalls for the whole frame.
// Reset: synchronous, active low; the hop length returns to 16, fill, hop
//   count and write pointer clear. The sample ring is not cleared.
// A stalled output word holds until taken; the next bin starts only then.
module hamming_windowed_stft import hws_pkg::*; #(
    parameter int P_FRAME_SIZE = FRAME_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_restart,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [BIN_W-1:0]           o_bin,
    output logic signed [OUT_W-1:0]    o_real_part,
    output logic signed [OUT_W-1:0]    o_imag_part,
    output logic                       o_last_bin,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [HOP_W-1:0]           i_cfg_data
);

`include "hamming_windowed_stft_macros.svh"

    localparam int AW     = $clog2(P_FRAME_SIZE);
    localparam int FILL_W = $clog2(P_FRAME_SIZE + 1);
    localparam logic [AW-1:0]   LAST_IDX = AW'(P_FRAME_SIZE - 1);
    localparam logic [AW:0]     N_WIDE   = (AW+1)'(P_FRAME_SIZE);
    localparam logic [FILL_W-1:0] N_FILL = FILL_W'(P_FRAME_SIZE);

    t_state r_state, n_state;

    logic [HOP_W-1:0]  r_hop;
    logic [AW-1:0]     r_wp;
    logic [FILL_W-1:0] r_fill;
    logic [HOP_W-1:0]  r_hopc;
    logic [AW-1:0]     r_base, r_k, r_n, r_m, r_n1, r_m1;
    logic              r_issue, r_v1, r_clr;
    logic signed [SAMPLE_W-1:0] r_rd;
    logic signed [SAMPLE_W-1:0] ring [P_FRAME_SIZE];

    logic              in_acc, due, done, out_take;
    logic [AW-1:0]     wp_inc, addr, m_inc;
    logic [AW:0]       addr_sum, m_sum;
    logic [FILL_W-1:0] fill_rs, n_fill;
    logic [HOP_W-1:0]  hopc_rs, n_hopc, hop_eff;

    t_mac_ctl          mac_ctl;
    t_mac_sts          mac_sts;
    logic signed [OUT_W-1:0] mac_re, mac_im;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = o_out_valid && !i_out_stall;
    assign hop_eff  = (r_hop == '0) ? HOP_W'(1) : r_hop;
    assign wp_inc   = (r_wp == LAST_IDX) ? '0 : r_wp + AW'(1);

    // frame-due decision for the sample being accepted
    always_comb begin
        fill_rs = i_restart ? '0 : r_fill;
        hopc_rs = i_restart ? '0 : r_hopc;
        due     = 1'b0;
        n_fill  = fill_rs;
        n_hopc  = hopc_rs;
        if (fill_rs < N_FILL) begin
            n_fill = fill_rs + FILL_W'(1);
            if (n_fill == N_FILL) begin
                due    = 1'b1;
                n_hopc = '0;
            end
        end else begin
            n_hopc = hopc_rs + HOP_W'(1);
            if (n_hopc >= hop_eff) begin
                due    = 1'b1;
                n_hopc = '0;
            end
        end
    end

    // ring address of tap n and twiddle index step, both wrapped at N
    assign addr_sum = (AW+1)'(r_base) + (AW+1)'(r_n);
    assign addr     = (addr_sum >= N_WIDE) ? AW'(addr_sum - N_WIDE) : AW'(addr_sum);
    assign m_sum    = (AW+1)'(r_m) + (AW+1)'(r_k);
    assign m_inc    = (m_sum >= N_WIDE) ? AW'(m_sum - N_WIDE) : AW'(m_sum);

    assign done = !r_issue && !r_v1 && !mac_sts.busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && due) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = (r_k == LAST_IDX) ? S_IDLE : S_MAC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            ring[r_wp] <= i_sample;
        end
        r_rd <= ring[addr];
    end

    // sequencer and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop   <= HOP_RESET;
            r_wp    <= '0;
            r_fill  <= '0;
            r_hopc  <= '0;
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_clr   <= 1'b0;
            r_k     <= '0;
            r_n     <= '0;
            r_m     <= '0;
            r_base  <= '0;
        end else begin
            r_clr <= 1'b0;
            r_v1  <= r_issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_hop <= i_cfg_data;
            end
            if (in_acc) begin
                r_wp   <= wp_inc;
                r_fill <= n_fill;
                r_hopc <= n_hopc;
                if (due) begin
                    // oldest sample sits where the pointer lands next
                    r_base  <= wp_inc;
                    r_k     <= '0;
                    r_n     <= '0;
                    r_m     <= '0;
                    r_issue <= 1'b1;
                    r_clr   <= 1'b1;
                end
            end
            if (r_issue) begin
                r_n <= r_n + AW'(1);
                r_m <= m_inc;
                if (r_n == LAST_IDX) begin
                    r_issue <= 1'b0;
                end
            end
            if (out_take && r_k != LAST_IDX) begin
                // advance to the next bin
                r_k     <= r_k + AW'(1);
                r_n     <= '0;
                r_m     <= '0;
                r_issue <= 1'b1;
                r_clr   <= 1'b1;
            end
        end
    end

    // indexes travel alongside the ring read
    always_ff @(posedge i_clk) begin
        r_n1 <= r_n;
        r_m1 <= r_m;
    end

    assign mac_ctl.vld = r_v1;
    assign mac_ctl.clr = r_clr;

    hws_mac #(
        .P_FRAME_SIZE(P_FRAME_SIZE)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (r_rd),
        .i_n      (r_n1),
        .i_m      (r_m1),
        .o_sts    (mac_sts),
        .o_re     (mac_re),
        .o_im     (mac_im)
    );

    // output word register, loaded when a bin finishes
    always_ff @(posedge i_clk) begin
        if (r_state == S_MAC && done) begin
            o_bin       <= BIN_W'(r_k);
            o_real_part <= mac_re;
            o_imag_part <= mac_im;
            o_last_bin  <= (r_k == LAST_IDX);
        end
    end

    `HWS_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= N_FILL, "fill count above frame size")
    `HWS_ASSERT_ALWAYS(a_last_idx, i_clk, i_rst_n, !o_out_valid || (o_last_bin == (o_bin == BIN_W'(LAST_IDX))), "last flag off the final bin")
    `HWS_ASSERT_NEXT(a_frame_end, i_clk, i_rst_n, out_take && o_last_bin, !o_in_stall && !r_issue, "frame end did not return to idle")
    `HWS_ASSERT_ALWAYS(a_no_mac_idle, i_clk, i_rst_n, !(r_state == S_IDLE && (r_issue || r_v1)), "products issued while idle")

endmodule

>>> rtl/hws_mac.sv
// Window, twiddle and accumulate datapath of the STFT.
// Depends on hws_pkg for the table functions and control structs.
module hws_mac import hws_pkg::*; #(
    parameter int P_FRAME_SIZE = FRAME_SIZE_DEF,
    localparam int AW = $clog2(P_FRAME_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mac_ctl                    i_ctl,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic [AW-1:0]               i_n,
    input  logic [AW-1:0]               i_m,
    output t_mac_sts                    o_sts,
    output logic signed [OUT_W-1:0]     o_re,
    output logic signed [OUT_W-1:0]     o_im
);

    localparam int XW_W  = 32;
    localparam int PR_W  = 48;
    localparam int ACC_W = PR_W + AW;
    localparam int SH_W  = ACC_W + 1 - 30;

    logic signed [15:0] w_rom [P_FRAME_SIZE];
    logic signed [15:0] c_rom [P_FRAME_SIZE];
    logic signed [15:0] s_rom [P_FRAME_SIZE];

    for (genvar g = 0; g < P_FRAME_SIZE; g++) begin : g_rom
        localparam logic signed [15:0] W = hws_window(g, P_FRAME_SIZE);
        localparam logic signed [15:0] C = hws_cos(g, P_FRAME_SIZE);
        localparam logic signed [15:0] S = hws_sin(g, P_FRAME_SIZE);
        assign w_rom[g] = W;
        assign c_rom[g] = C;
        assign s_rom[g] = S;
    end

    logic                     r_v2, r_v3;
    logic signed [XW_W-1:0]   r_xw;
    logic [AW-1:0]            r_m2;
    logic signed [PR_W-1:0]   r_pre, r_pim;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.vld;
            r_v3 <= r_v2;
        end
    end

    // window, then twiddle, then accumulate; one register after each product
    always_ff @(posedge i_clk) begin
        r_xw  <= XW_W'(i_sample) * XW_W'(w_rom[i_n]);
        r_m2  <= i_m;
        r_pre <= PR_W'(r_xw) * PR_W'(c_rom[r_m2]);
        r_pim <= PR_W'(r_xw) * PR_W'(s_rom[r_m2]);
        if (i_ctl.clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v3) begin
            r_acc_re <= r_acc_re + ACC_W'(r_pre);
            r_acc_im <= r_acc_im - ACC_W'(r_pim);
        end
    end

    // round half up, drop 30 fraction bits, saturate to the output width
    function automatic logic signed [OUT_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0]  s;
        logic signed [SH_W-1:0] r;
        s = (ACC_W+1)'(v) + (ACC_W+1)'(64'sd1 << 29);
        r = SH_W'(s >>> 30);
        if (r > SH_W'((64'sd1 << (OUT_W-1)) - 1)) begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r < -SH_W'(64'sd1 << (OUT_W-1))) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end
        return OUT_W'(r);
    endfunction

    assign o_re       = rnd_sat(r_acc_re);
    assign o_im       = rnd_sat(r_acc_im);
    assign o_sts.busy = r_v2 | r_v3;

endmodule
